/* sv/chmt_pkg.sv */
// Shared constants for the caret height median tracker.
package chmt_pkg;

    localparam int DEF_MONITOR_SLOTS = 4;
    localparam int DEF_HISTORY_DEPTH = 8;

    localparam int HEIGHT_W   = 12;
    localparam int WIDTH_W    = 12;
    localparam int SAMPLE_W   = 7;
    localparam int FALLBACK_W = 8;

    localparam logic [HEIGHT_W-1:0]   SMALL_HEIGHT_MAX = 12'd4;
    localparam logic [HEIGHT_W-1:0]   TRUST_HEIGHT_MIN = 12'd5;
    localparam logic [HEIGHT_W-1:0]   TRUST_HEIGHT_MAX = 12'd64;
    localparam logic [WIDTH_W-1:0]    TRUST_WIDTH_MAX  = 12'd4;
    localparam logic [HEIGHT_W-1:0]   BAND_FLOOR       = 12'd6;
    localparam logic [FALLBACK_W-1:0] FALLBACK_RESET   = 8'd20;

    typedef enum logic [1:0] {
        SRC_MEASURED = 2'd0,
        SRC_HISTORY  = 2'd1,
        SRC_FALLBACK = 2'd2
    } t_source;

endpackage

/* sv/chmt_rank.sv */
// Rank test that tells whether a candidate sample is the upper median of a buffer.
module chmt_rank
    import chmt_pkg::*;
#(
    parameter int DEPTH = DEF_HISTORY_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic [SAMPLE_W-1:0] i_samples [DEPTH],
    input  logic [CNT_W-1:0]    i_count,
    input  logic [SAMPLE_W-1:0] i_value,
    output logic                o_hit
);

    logic [CNT_W-1:0] n_less;
    logic [CNT_W-1:0] n_less_eq;
    logic [CNT_W-1:0] target;

    assign target = i_count >> 1;

    always_comb begin
        n_less    = '0;
        n_less_eq = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (CNT_W'(j) < i_count) begin
                n_less    = n_less + CNT_W'(i_samples[j] < i_value);
                n_less_eq = n_less_eq + CNT_W'(i_samples[j] <= i_value);
            end
        end
    end

    assign o_hit = (n_less <= target) && (target < n_less_eq);

endmodule

/* sv/caret_height_median_tracker.sv */
// Top level of the caret height median tracker with its history memory.
//
// An observation beat is taken on a rising edge with start high and busy low.
// Each observation yields exactly one result, shown on the result ports for one
// cycle while o_done is high; the receiver cannot hold results off.
// The fallback height is written through the cfg channel while the block is idle.
// When no median is needed the beat goes straight to the finish state.
// When the slot holds n samples and a median is needed, the samples are read
// from the history memory one per cycle, then candidates are ranked one per
// cycle (at most n of them) until the upper median is found, and the finish
// state registers the result.
// The single read port of the history memory sets the length of the read pass.
// Busy falls in the cycle the result is shown, so the next beat may be taken then.
// Reset empties every slot and restores the fallback height of 20; no clearing
// pass is needed, as only written entries are ever read.
module caret_height_median_tracker
    import chmt_pkg::*;
#(
    parameter int MONITOR_SLOTS = DEF_MONITOR_SLOTS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_monitor_slot,
    input  logic                  i_monitor_known,
    input  logic [WIDTH_W-1:0]    i_caret_width,
    input  logic [HEIGHT_W-1:0]   i_caret_height,
    output logic                  o_done,
    output logic [HEIGHT_W-1:0]   o_effective_height,
    output logic [1:0]            o_height_source,
    output logic                  o_sample_recorded,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [FALLBACK_W-1:0] i_cfg_data
);

    localparam int SLOT_W    = (MONITOR_SLOTS > 1) ? $clog2(MONITOR_SLOTS) : 1;
    localparam int POS_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int MEM_DEPTH = MONITOR_SLOTS * HISTORY_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_FINISH} t_state;

    t_state                r_state;
    logic                  r_done;
    logic [HEIGHT_W-1:0]   r_eff;
    t_source               r_src;
    logic                  r_rec;
    logic [FALLBACK_W-1:0] r_fallback;
    logic [CNT_W-1:0]      r_hist_cnt  [MONITOR_SLOTS];
    logic [POS_W-1:0]      r_hist_head [MONITOR_SLOTS];
    logic [CNT_W-1:0]      r_pos;
    logic                  r_rd_pend;
    logic [SAMPLE_W-1:0]   r_med;

    logic [SLOT_W-1:0]     r_slot;
    logic                  r_known;
    logic [WIDTH_W-1:0]    r_width;
    logic [HEIGHT_W-1:0]   r_height;
    logic [CNT_W-1:0]      r_cnt;
    logic [POS_W-1:0]      r_head;
    logic [POS_W-1:0]      r_rd_pos;
    logic [SAMPLE_W-1:0]   r_buf [HISTORY_DEPTH];

    logic [SAMPLE_W-1:0]   mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0]   r_rd_data;

    logic                  accept;
    logic [SLOT_W-1:0]     in_slot;
    logic                  in_known;
    logic [CNT_W-1:0]      in_cnt;
    logic                  need_med;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [SAMPLE_W-1:0]   cand;
    logic                  rank_hit;
    logic                  low_height;
    logic                  trusted;
    logic                  band_ok;
    logic                  rec;
    logic [SAMPLE_W-1:0]   h7;
    logic [9:0]            h10;
    logic [9:0]            m10;
    logic [CNT_W:0]        pos_sum;
    logic [POS_W-1:0]      wr_pos;
    logic [CNT_W-1:0]      n_cnt;
    logic [POS_W-1:0]      n_head;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = start && !busy;

    assign in_slot  = SLOT_W'(i_monitor_slot);
    assign in_known = i_monitor_known && (int'(i_monitor_slot) < MONITOR_SLOTS);
    assign in_cnt   = in_known ? r_hist_cnt[in_slot] : '0;
    assign need_med = in_known && (in_cnt != '0) &&
                      ((i_caret_height <= SMALL_HEIGHT_MAX) ||
                       ((i_caret_height <= TRUST_HEIGHT_MAX) &&
                        (i_caret_width <= TRUST_WIDTH_MAX)));

    assign rd_addr = ADDR_W'(r_slot) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(r_pos[POS_W-1:0]);
    assign cand    = r_buf[r_pos[POS_W-1:0]];

    chmt_rank #(
        .DEPTH (HISTORY_DEPTH),
        .CNT_W (CNT_W)
    ) u_rank (
        .i_samples (r_buf),
        .i_count   (r_cnt),
        .i_value   (cand),
        .o_hit     (rank_hit)
    );

    assign low_height = (r_height <= SMALL_HEIGHT_MAX);
    assign trusted    = r_known && (r_height >= TRUST_HEIGHT_MIN) &&
                        (r_height <= TRUST_HEIGHT_MAX) && (r_width <= TRUST_WIDTH_MAX);
    assign h7         = r_height[SAMPLE_W-1:0];
    assign h10        = 10'(h7);
    assign m10        = 10'(r_med);
    assign band_ok    = (r_cnt == '0) ||
                        ((r_height >= BAND_FLOOR) && ((h10 << 1) >= m10) &&
                         (h10 * 10'd5 <= m10 * 10'd9));
    assign rec        = !low_height && trusted && band_ok;

    // A full ring gives head + depth - depth, which is the oldest entry.
    assign pos_sum = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_cnt);
    assign wr_pos  = (pos_sum >= (CNT_W + 1)'(HISTORY_DEPTH)) ?
                     POS_W'(pos_sum - (CNT_W + 1)'(HISTORY_DEPTH)) : POS_W'(pos_sum);
    assign wr_addr = ADDR_W'(r_slot) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(wr_pos);
    assign n_cnt   = (r_cnt < CNT_W'(HISTORY_DEPTH)) ? r_cnt + 1'b1 : r_cnt;
    assign n_head  = (r_cnt < CNT_W'(HISTORY_DEPTH)) ? r_head :
                     ((r_head == POS_W'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_eff      <= '0;
            r_src      <= SRC_MEASURED;
            r_rec      <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_pos      <= '0;
            r_fallback <= FALLBACK_RESET;
            for (int s = 0; s < MONITOR_SLOTS; s++) begin
                r_hist_cnt[s]  <= '0;
                r_hist_head[s] <= '0;
            end
        end else begin
            r_done    <= 1'b0;
            r_rd_pend <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fallback <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos   <= '0;
                        r_state <= need_med ? S_READ : S_FINISH;
                    end
                end
                S_READ: begin
                    if (r_pos != r_cnt) begin
                        r_rd_pend <= 1'b1;
                        r_pos     <= r_pos + 1'b1;
                    end else begin
                        r_pos   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rank_hit) begin
                        r_med   <= cand;
                        r_state <= S_FINISH;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_FINISH: begin
                    r_done <= 1'b1;
                    r_rec  <= rec;
                    if (low_height) begin
                        if (r_cnt != '0) begin
                            r_eff <= HEIGHT_W'(r_med);
                            r_src <= SRC_HISTORY;
                        end else begin
                            r_eff <= HEIGHT_W'(r_fallback);
                            r_src <= SRC_FALLBACK;
                        end
                    end else begin
                        r_eff <= r_height;
                        r_src <= SRC_MEASURED;
                    end
                    if (rec) begin
                        r_hist_cnt[r_slot]  <= n_cnt;
                        r_hist_head[r_slot] <= n_head;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot   <= in_slot;
            r_known  <= in_known;
            r_width  <= i_caret_width;
            r_height <= i_caret_height;
            r_cnt    <= in_cnt;
            r_head   <= in_known ? r_hist_head[in_slot] : '0;
        end
        if (r_state == S_READ) begin
            r_rd_pos <= r_pos[POS_W-1:0];
        end
        if (r_rd_pend) begin
            r_buf[r_rd_pos] <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        if ((r_state == S_FINISH) && rec) begin
            mem[wr_addr] <= h7;
        end
    end

    assign o_done             = r_done;
    assign o_effective_height = r_eff;
    assign o_height_source    = r_src;
    assign o_sample_recorded  = r_rec;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_rec_measured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_sample_recorded) |-> (o_height_source == SRC_MEASURED))
        else $error("sample recorded without a measured height");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> (r_cnt <= CNT_W'(HISTORY_DEPTH)))
        else $error("slot count beyond history depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_pos < r_cnt))
        else $error("median scan ran past the held samples");

endmodule

/* tb/tb_caret_height_median_tracker.sv */
// Self-checking testbench for the caret height median tracker with an in-bench history predictor.
`timescale 1ns / 100ps

module tb_caret_height_median_tracker;
    import chmt_pkg::*;

    localparam int LATENCY_MAX  = 19;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        t_source             source;
        logic                recorded;
    } t_caret_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_monitor_slot = '0;
    logic                  i_monitor_known = 1'b0;
    logic [WIDTH_W-1:0]    i_caret_width = '0;
    logic [HEIGHT_W-1:0]   i_caret_height = '0;
    logic                  o_done;
    logic [HEIGHT_W-1:0]   o_effective_height;
    logic [1:0]            o_height_source;
    logic                  o_sample_recorded;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [FALLBACK_W-1:0] i_cfg_data = '0;

    logic [SAMPLE_W-1:0]   trusted_heights [DEF_MONITOR_SLOTS][DEF_HISTORY_DEPTH];
    logic [3:0]            trusted_count [DEF_MONITOR_SLOTS];
    logic [2:0]            oldest_pos [DEF_MONITOR_SLOTS];
    logic [FALLBACK_W-1:0] fallback_model;

    t_caret_result pending_results [$];
    int            mismatch_count = 0;
    logic          gaps_on = 1'b1;

    caret_height_median_tracker dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_monitor_slot     (i_monitor_slot),
        .i_monitor_known    (i_monitor_known),
        .i_caret_width      (i_caret_width),
        .i_caret_height     (i_caret_height),
        .o_done             (o_done),
        .o_effective_height (o_effective_height),
        .o_height_source    (o_height_source),
        .o_sample_recorded  (o_sample_recorded),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [SAMPLE_W-1:0] slot_upper_median(input int s);
        logic [SAMPLE_W-1:0] vals [DEF_HISTORY_DEPTH];
        logic [SAMPLE_W-1:0] v;
        int n;
        int i;
        int j;
        n = trusted_count[s];
        for (i = 0; i < n; i++) vals[i] = trusted_heights[s][i];
        for (i = 1; i < n; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > v) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        return vals[n/2];
    endfunction

    function automatic t_caret_result predict_observation(input logic [1:0] slot,
                                                          input logic known,
                                                          input logic [WIDTH_W-1:0] w,
                                                          input logic [HEIGHT_W-1:0] h);
        t_caret_result r;
        int m;
        int n;
        logic ok;
        r.recorded = 1'b0;
        if (h <= SMALL_HEIGHT_MAX) begin
            if (known && trusted_count[slot] != 0) begin
                r.height = HEIGHT_W'(slot_upper_median(slot));
                r.source = SRC_HISTORY;
            end else begin
                r.height = HEIGHT_W'(fallback_model);
                r.source = SRC_FALLBACK;
            end
        end else begin
            r.height = h;
            r.source = SRC_MEASURED;
            if (known && h >= TRUST_HEIGHT_MIN && h <= TRUST_HEIGHT_MAX &&
                w <= TRUST_WIDTH_MAX) begin
                ok = 1'b1;
                if (trusted_count[slot] != 0) begin
                    m = slot_upper_median(slot);
                    if (h < BAND_FLOOR || 2 * int'(h) < m || 5 * int'(h) > 9 * m) ok = 1'b0;
                end
                if (ok) begin
                    n = trusted_count[slot];
                    if (n < DEF_HISTORY_DEPTH) begin
                        trusted_heights[slot][(oldest_pos[slot] + n) % DEF_HISTORY_DEPTH] =
                            h[SAMPLE_W-1:0];
                        trusted_count[slot] = trusted_count[slot] + 4'd1;
                    end else begin
                        trusted_heights[slot][oldest_pos[slot]] = h[SAMPLE_W-1:0];
                        oldest_pos[slot] = oldest_pos[slot] + 3'd1;
                    end
                    r.recorded = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_caret_result due);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected height %0d source %0d recorded %0d, got %0d %0d %0d",
                     $realtime, what, due.height, due.source, due.recorded,
                     o_effective_height, o_height_source, o_sample_recorded);
    endtask

    always @(posedge i_clk) begin : result_check
        t_caret_result due;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                due = '0;
                report_mismatch("result with nothing outstanding", due);
            end else begin
                due = pending_results.pop_front();
                if (o_effective_height !== due.height || o_height_source !== due.source ||
                    o_sample_recorded !== due.recorded)
                    report_mismatch("result mismatch", due);
            end
        end
    end

    task automatic send_observation(input logic [1:0] slot, input logic known,
                                    input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_monitor_slot  <= slot;
        i_monitor_known <= known;
        i_caret_width   <= w;
        i_caret_height  <= h;
        do @(posedge i_clk); while (busy);
        pending_results.insert(pending_results.size(), predict_observation(slot, known, w, h));
    endtask

    task automatic wait_idle();
        @(negedge i_clk) start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY_MAX) @(posedge i_clk);
    endtask

    task automatic write_fallback(input logic [FALLBACK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        fallback_model = value;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_reset();
        for (int s = 0; s < DEF_MONITOR_SLOTS; s++) begin
            trusted_count[s] = '0;
            oldest_pos[s]    = '0;
            for (int d = 0; d < DEF_HISTORY_DEPTH; d++) trusted_heights[s][d] = '0;
        end
        fallback_model = FALLBACK_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    endtask

    task automatic test_empty_slots();
        send_observation(2'd0, 1'b1, 12'd0, 12'd0);
        send_observation(2'd1, 1'b0, 12'd4095, 12'd4);
        send_observation(2'd3, 1'b0, 12'd0, 12'd30);
        send_observation(2'd0, 1'b1, 12'd4095, 12'd4095);
        send_observation(2'd0, 1'b1, 12'd5, 12'd20);
    endtask

    task automatic test_first_samples();
        send_observation(2'd0, 1'b1, 12'd4, 12'd5);
        send_observation(2'd1, 1'b1, 12'd0, 12'd64);
        send_observation(2'd1, 1'b1, 12'd0, 12'd65);
        send_observation(2'd0, 1'b1, 12'd0, 12'd4);
    endtask

    task automatic test_trust_band();
        send_observation(2'd2, 1'b1, 12'd0, 12'd10);
        send_observation(2'd2, 1'b1, 12'd0, 12'd6);
        send_observation(2'd2, 1'b1, 12'd0, 12'd18);
        send_observation(2'd2, 1'b1, 12'd0, 12'd19);
        send_observation(2'd2, 1'b1, 12'd0, 12'd5);
        send_observation(2'd3, 1'b1, 12'd0, 12'd40);
        send_observation(2'd3, 1'b1, 12'd0, 12'd19);
        send_observation(2'd3, 1'b1, 12'd0, 12'd20);
        send_observation(2'd3, 1'b1, 12'd1, 12'd3);
    endtask

    task automatic test_ring_eviction();
        int vals [8] = '{6, 7, 8, 9, 9, 8, 7, 6};
        foreach (vals[k]) send_observation(2'd0, 1'b1, 12'd2, HEIGHT_W'(vals[k]));
        send_observation(2'd0, 1'b1, 12'd0, 12'd1);
    endtask

    task automatic test_random_observations(input int count);
        logic [1:0]          slot;
        logic                known;
        logic [WIDTH_W-1:0]  w;
        logic [HEIGHT_W-1:0] h;
        int kind;
        int m;
        int lo;
        int hi;
        for (int k = 0; k < count; k++) begin
            slot  = 2'($urandom_range(0, 3));
            kind  = $urandom_range(0, 99);
            known = 1'b1;
            w     = WIDTH_W'($urandom_range(0, 4));
            if (kind < 45) begin
                if (trusted_count[slot] != 0) begin
                    m  = slot_upper_median(slot);
                    lo = (m / 2 > 4) ? m / 2 - 1 : 3;
                    hi = (2 * m < 70) ? 2 * m : 70;
                    h  = HEIGHT_W'($urandom_range(hi, lo));
                end else begin
                    h = HEIGHT_W'($urandom_range(5, 64));
                end
            end else if (kind < 75) begin
                h     = HEIGHT_W'($urandom_range(0, 4));
                known = ($urandom_range(0, 9) != 0);
                w     = WIDTH_W'($urandom_range(0, 4095));
            end else if (kind < 88) begin
                known = 1'($urandom_range(0, 1));
                w     = WIDTH_W'($urandom_range(0, 4095));
                h     = HEIGHT_W'($urandom_range(0, 4095));
            end else begin
                known = 1'($urandom_range(0, 1));
                w     = WIDTH_W'($urandom_range(0, 8));
                h     = HEIGHT_W'($urandom_range(56, 72));
            end
            send_observation(slot, known, w, h);
        end
    endtask

    initial begin
        apply_reset();
        test_empty_slots();
        test_first_samples();
        test_trust_band();
        test_ring_eviction();
        wait_idle();
        write_fallback(8'd255);
        test_random_observations(150);
        wait_idle();
        write_fallback(FALLBACK_W'($urandom_range(21, 254)));
        test_random_observations(150);
        wait_idle();
        write_fallback(8'd20);
        test_random_observations(100);
        wait_idle();
        write_fallback(FALLBACK_W'($urandom_range(20, 255)));
        gaps_on = 1'b0;
        test_random_observations(100);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
